// File: hdl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Transaction types, trim set, pipeline constants and arithmetic helpers.
// No dependencies.
package bpc_pkg;

   localparam int TRIM_W     = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int FRONT_DEPTH = 8;
   localparam int DIV_STAGES  = 32;
   localparam int BACK_DEPTH  = 3;
   localparam int PIPE_DEPTH  = FRONT_DEPTH + DIV_STAGES + BACK_DEPTH;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_TRIM    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_TRIM_C = 2'd3;

   localparam logic [31:0] TEMP_OFFSET = 32'd64000;
   localparam logic [31:0] PRESS_FULL  = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE = 32'd3125;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
   localparam logic [31:0] DIG_ONE     = 32'd32768;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic [31:0]        pressure_pa;
      logic signed [31:0] temp_fine;
      logic               valid_res;
   } rsp_type;

   typedef struct packed {
      logic [TRIM_W-1:0] temp_trim;
      logic [TRIM_W-1:0] press_trim_a;
      logic [TRIM_W-1:0] press_trim_b;
      logic [TRIM_W-1:0] press_trim_c;
   } trims_type;

   typedef struct packed {
      logic [31:0] fine;
      logic        ok;
      logic        dbl;
   } tag_type;

   function automatic logic [31:0] sra32(logic [31:0] x, logic [4:0] n);
      sra32 = $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic [63:0] prod;
      prod = a * b;
      mul32 = prod[31:0];
   endfunction

   function automatic logic [31:0] sx16(logic [15:0] w);
      sx16 = {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] zx16(logic [15:0] w);
      zx16 = {16'd0, w};
   endfunction

endpackage

// File: hdl/bpc_front.sv
// Front pipeline: fine temperature, pressure coefficients and divider operands.
// Depends on bpc_pkg.
module bpc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  bpc_pkg::req_type   in_data,
   input  bpc_pkg::trims_type trims,
   output logic               out_vld,
   output logic [31:0]        out_num,
   output logic [31:0]        out_den,
   output bpc_pkg::tag_type   out_tag
);

   logic [bpc_pkg::FRONT_DEPTH-1:0] vld_ff;
   logic [bpc_pkg::FRONT_DEPTH-1:0] vld_in;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
   logic [31:0] adc_t, adc_p, x1, d;
   logic [31:0] a4_in, a3_in, pn_in, pa_in;

   logic [31:0] adcp1_ff, m1_ff, dd_ff;
   logic [31:0] adcp2_ff, a2_ff, m2_ff;
   logic [31:0] adcp3_ff, fine3_ff;
   logic [31:0] adcp4_ff, fine4_ff, pa4_ff, q4_ff;
   logic [31:0] adcp5_ff, fine5_ff, b5_ff, m5_ff, m3_ff, mp2_ff;
   logic [31:0] adcp6_ff, fine6_ff, b6_ff, a6_ff;
   logic [31:0] fine7_ff, a7_ff, pn7_ff;
   logic [31:0] num_ff, den_ff;
   bpc_pkg::tag_type tag_ff;

   assign t1 = bpc_pkg::zx16(trims.temp_trim[15:0]);
   assign t2 = bpc_pkg::sx16(trims.temp_trim[31:16]);
   assign t3 = bpc_pkg::sx16(trims.temp_trim[47:32]);
   assign p1 = bpc_pkg::zx16(trims.press_trim_a[15:0]);
   assign p2 = bpc_pkg::sx16(trims.press_trim_a[31:16]);
   assign p3 = bpc_pkg::sx16(trims.press_trim_a[47:32]);
   assign p4 = bpc_pkg::sx16(trims.press_trim_b[15:0]);
   assign p5 = bpc_pkg::sx16(trims.press_trim_b[31:16]);
   assign p6 = bpc_pkg::sx16(trims.press_trim_b[47:32]);

   assign adc_t = {12'd0, in_data.raw_temperature};
   assign adc_p = {12'd0, in_data.raw_pressure};
   assign x1    = (adc_t >> 3) - (t1 << 1);
   assign d     = (adc_t >> 4) - t1;
   assign pa_in = bpc_pkg::sra32(fine3_ff, 5'd1) - bpc_pkg::TEMP_OFFSET;
   assign a4_in = bpc_pkg::sra32(
                     bpc_pkg::sra32(m3_ff, 5'd3) + bpc_pkg::sra32(mp2_ff, 5'd1), 5'd18);
   assign a3_in = bpc_pkg::mul32(bpc_pkg::DIG_ONE + a6_ff, p1);
   assign pn_in = bpc_pkg::mul32(
                     (bpc_pkg::PRESS_FULL - adcp6_ff) - bpc_pkg::sra32(b6_ff, 5'd12),
                     bpc_pkg::PRESS_SCALE);
   assign vld_in = {vld_ff[bpc_pkg::FRONT_DEPTH-2:0], in_vld};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      adcp1_ff <= adc_p;
      m1_ff    <= bpc_pkg::mul32(x1, t2);
      dd_ff    <= bpc_pkg::mul32(d, d);

      adcp2_ff <= adcp1_ff;
      a2_ff    <= bpc_pkg::sra32(m1_ff, 5'd11);
      m2_ff    <= bpc_pkg::mul32(bpc_pkg::sra32(dd_ff, 5'd12), t3);

      adcp3_ff <= adcp2_ff;
      fine3_ff <= a2_ff + bpc_pkg::sra32(m2_ff, 5'd14);

      adcp4_ff <= adcp3_ff;
      fine4_ff <= fine3_ff;
      pa4_ff   <= pa_in;
      q4_ff    <= bpc_pkg::mul32(bpc_pkg::sra32(pa_in, 5'd2), bpc_pkg::sra32(pa_in, 5'd2));

      adcp5_ff <= adcp4_ff;
      fine5_ff <= fine4_ff;
      b5_ff    <= bpc_pkg::mul32(bpc_pkg::sra32(q4_ff, 5'd11), p6);
      m5_ff    <= bpc_pkg::mul32(pa4_ff, p5);
      m3_ff    <= bpc_pkg::mul32(p3, bpc_pkg::sra32(q4_ff, 5'd13));
      mp2_ff   <= bpc_pkg::mul32(p2, pa4_ff);

      adcp6_ff <= adcp5_ff;
      fine6_ff <= fine5_ff;
      b6_ff    <= bpc_pkg::sra32(b5_ff + (m5_ff << 1), 5'd2) + (p4 << 16);
      a6_ff    <= a4_in;

      fine7_ff <= fine6_ff;
      a7_ff    <= a3_in;
      pn7_ff   <= pn_in;

      den_ff     <= bpc_pkg::sra32(a7_ff, 5'd15);
      num_ff     <= (pn7_ff < bpc_pkg::SIGN_BIT) ? (pn7_ff << 1) : pn7_ff;
      tag_ff.fine <= fine7_ff;
      tag_ff.ok   <= (bpc_pkg::sra32(a7_ff, 5'd15) != 32'd0);
      tag_ff.dbl  <= (pn7_ff >= bpc_pkg::SIGN_BIT);
   end

   assign out_vld = vld_ff[bpc_pkg::FRONT_DEPTH-1];
   assign out_num = num_ff;
   assign out_den = den_ff;
   assign out_tag = tag_ff;

endmodule

// File: hdl/bpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned 32 by 32.
// Depends on bpc_pkg.
module bpc_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   input  logic [31:0]      in_num,
   input  logic [31:0]      in_den,
   input  bpc_pkg::tag_type in_tag,
   output logic             out_vld,
   output logic [31:0]      out_quo,
   output bpc_pkg::tag_type out_tag
);

   localparam int N = bpc_pkg::DIV_STAGES;

   logic [N-1:0]     vld_ff;
   logic [31:0]      rem_ff [N];
   logic [31:0]      num_ff [N];
   logic [31:0]      den_ff [N];
   bpc_pkg::tag_type tag_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[N-2:0], in_vld};
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [31:0]      rem_p, num_p, den_p;
      bpc_pkg::tag_type tag_p;
      logic [32:0]      r;
      logic             ge;
      if (i == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = in_num;
         assign den_p = in_den;
         assign tag_p = in_tag;
      end else begin : g_next
         assign rem_p = rem_ff[i-1];
         assign num_p = num_ff[i-1];
         assign den_p = den_ff[i-1];
         assign tag_p = tag_ff[i-1];
      end
      assign r  = {rem_p, num_p[31]};
      assign ge = (r >= {1'b0, den_p});
      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? 32'(r - {1'b0, den_p}) : r[31:0];
         num_ff[i] <= {num_p[30:0], ge};
         den_ff[i] <= den_p;
         tag_ff[i] <= tag_p;
      end
   end

   assign out_vld = vld_ff[N-1];
   assign out_quo = num_ff[N-1];
   assign out_tag = tag_ff[N-1];

endmodule

// File: hdl/bpc_back.sv
// Back pipeline: nonlinear pressure correction and result register.
// Depends on bpc_pkg.
module bpc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic [31:0]        in_quo,
   input  bpc_pkg::tag_type   in_tag,
   input  bpc_pkg::trims_type trims,
   output logic               out_vld,
   output bpc_pkg::rsp_type   out_data
);

   logic [bpc_pkg::BACK_DEPTH-1:0] vld_ff;
   logic [31:0] p7, p8, p9, p_in, corr_in;
   logic [31:0] p1_ff, q1_ff, m1_ff;
   logic [31:0] p2_ff, m2_ff, b2_ff;
   bpc_pkg::tag_type tag1_ff, tag2_ff;
   bpc_pkg::rsp_type res_ff;

   assign p7 = bpc_pkg::sx16(trims.press_trim_c[15:0]);
   assign p8 = bpc_pkg::sx16(trims.press_trim_c[31:16]);
   assign p9 = bpc_pkg::sx16(trims.press_trim_c[47:32]);

   assign p_in    = in_tag.dbl ? {in_quo[30:0], 1'b0} : in_quo;
   assign corr_in = bpc_pkg::sra32(
                       bpc_pkg::sra32(m2_ff, 5'd12) + b2_ff + p7, 5'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[bpc_pkg::BACK_DEPTH-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p_in;
      q1_ff   <= bpc_pkg::mul32(p_in >> 3, p_in >> 3) >> 13;
      m1_ff   <= bpc_pkg::mul32(p_in >> 2, p8);
      tag1_ff <= in_tag;

      p2_ff   <= p1_ff;
      m2_ff   <= bpc_pkg::mul32(p9, q1_ff);
      b2_ff   <= bpc_pkg::sra32(m1_ff, 5'd13);
      tag2_ff <= tag1_ff;

      res_ff.pressure_pa <= tag2_ff.ok ? (p2_ff + corr_in) : 32'd0;
      res_ff.temp_fine   <= $signed(tag2_ff.fine);
      res_ff.valid_res   <= tag2_ff.ok;
   end

   assign out_vld  = vld_ff[bpc_pkg::BACK_DEPTH-1];
   assign out_data = res_ff;

endmodule

// File: hdl/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation block.
// Holds the trim registers; instantiates bpc_front, bpc_div and bpc_back; uses bpc_pkg.
//
//   port group | direction | handshake        | payload
//   req_       | in        | start / busy     | req_data (raw pressure, raw temperature)
//   rsp_       | out       | rsp_valid strobe | rsp_data (pressure, fine temp, valid)
//   csr_       | in        | csr_we           | csr_index, csr_wdata (48-bit trim word)
//
// One transaction enters per cycle; busy is never raised.
// Each result passes through 8 front stages, 32 divider
// stages (one quotient bit each), 3 back stages.
// Synchronous reset clears valid bits and trim registers; no clearing pass.
// The receiver cannot stall; results are never held.
module barometric_pressure_compensation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bpc_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output bpc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpc_pkg::TRIM_W-1:0]        csr_wdata
);

   bpc_pkg::trims_type trims_ff, trims_in;
   logic               f_vld, d_vld;
   logic [31:0]        f_num, f_den, d_quo;
   bpc_pkg::tag_type   f_tag, d_tag;

   assign busy = 1'b0;

   always_comb begin
      trims_in = trims_ff;
      if (csr_we) begin
         case (csr_index)
            bpc_pkg::CSR_TEMP_TRIM:    trims_in.temp_trim    = csr_wdata;
            bpc_pkg::CSR_PRESS_TRIM_A: trims_in.press_trim_a = csr_wdata;
            bpc_pkg::CSR_PRESS_TRIM_B: trims_in.press_trim_b = csr_wdata;
            bpc_pkg::CSR_PRESS_TRIM_C: trims_in.press_trim_c = csr_wdata;
            default:                   trims_in = trims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trims_ff <= '0;
      end else begin
         trims_ff <= trims_in;
      end
   end

   bpc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start & ~busy),
      .in_data (req_data),
      .trims   (trims_ff),
      .out_vld (f_vld),
      .out_num (f_num),
      .out_den (f_den),
      .out_tag (f_tag)
   );

   bpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (f_vld),
      .in_num  (f_num),
      .in_den  (f_den),
      .in_tag  (f_tag),
      .out_vld (d_vld),
      .out_quo (d_quo),
      .out_tag (d_tag)
   );

   bpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (d_vld),
      .in_quo   (d_quo),
      .in_tag   (d_tag),
      .trims    (trims_ff),
      .out_vld  (rsp_valid),
      .out_data (rsp_data)
   );

   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.pressure_pa == 32'd0)
      else $error("pressure not cleared on zero divisor");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !reset, bpc_pkg::PIPE_DEPTH))
      else $error("result strobe out of step with accepted transactions");

endmodule

// File: tb/bpc_checker.sv
// Checker for the barometric pressure compensation block.
// Watches the request, result and trim write ports, predicts each result and compares.
// Depends on bpc_pkg.
`timescale 1ns / 100ps

module bpc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  bpc_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  bpc_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpc_pkg::TRIM_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   logic [bpc_pkg::TRIM_W-1:0] trim_t, trim_pa, trim_pb, trim_pc;
   bpc_pkg::rsp_type           expected_q[$];

   function automatic logic [31:0] asr(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] lowmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] full;
      full = {32'd0, a} * {32'd0, b};
      return full[31:0];
   endfunction

   function automatic logic [31:0] s16(logic [bpc_pkg::TRIM_W-1:0] r, int pos);
      logic [15:0] w;
      w = r[pos +: 16];
      return {{16{w[15]}}, w};
   endfunction

   function automatic bpc_pkg::rsp_type compensate(bpc_pkg::req_type rq);
      logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, fine, p, q;
      bpc_pkg::rsp_type r;
      adc_p = {12'd0, rq.raw_pressure};
      adc_t = {12'd0, rq.raw_temperature};
      t1 = {16'd0, trim_t[15:0]};  t2 = s16(trim_t, 16);  t3 = s16(trim_t, 32);
      p1 = {16'd0, trim_pa[15:0]}; p2 = s16(trim_pa, 16); p3 = s16(trim_pa, 32);
      p4 = s16(trim_pb, 0); p5 = s16(trim_pb, 16); p6 = s16(trim_pb, 32);
      p7 = s16(trim_pc, 0); p8 = s16(trim_pc, 16); p9 = s16(trim_pc, 32);
      a = asr(lowmul((adc_t >> 3) - (t1 << 1), t2), 11);
      d = (adc_t >> 4) - t1;
      b = asr(lowmul(asr(lowmul(d, d), 12), t3), 14);
      fine = a + b;
      a = asr(fine, 1) - 32'd64000;
      q = lowmul(asr(a, 2), asr(a, 2));
      b = lowmul(asr(q, 11), p6);
      b = b + (lowmul(a, p5) << 1);
      b = asr(b, 2) + (p4 << 16);
      a = asr(asr(lowmul(p3, asr(q, 13)), 3) + asr(lowmul(p2, a), 1), 18);
      a = asr(lowmul(32'd32768 + a, p1), 15);
      r.temp_fine = fine;
      if (a == 0) begin
         r.valid_res = 1'b0;
         r.pressure_pa = '0;
      end else begin
         p = lowmul((32'd1048576 - adc_p) - asr(b, 12), 32'd3125);
         if (p < 32'h8000_0000) p = (p << 1) / a;
         else p = (p / a) * 32'd2;
         q = lowmul(p >> 3, p >> 3) >> 13;
         a = asr(lowmul(p9, q), 12);
         b = asr(lowmul(p >> 2, p8), 13);
         r.pressure_pa = p + asr(a + b + p7, 4);
         r.valid_res = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   assign pending = expected_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      bpc_pkg::rsp_type want;
      if (reset) begin
         trim_t <= '0; trim_pa <= '0; trim_pb <= '0; trim_pc <= '0;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.pressure_pa, 32'd0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.pressure_pa !== want.pressure_pa)
                  report_mismatch("pressure_pa", rsp_data.pressure_pa, want.pressure_pa);
               if (rsp_data.temp_fine !== want.temp_fine)
                  report_mismatch("temp_fine", rsp_data.temp_fine, want.temp_fine);
               if (rsp_data.valid_res !== want.valid_res)
                  report_mismatch("valid_res", {31'd0, rsp_data.valid_res},
                                  {31'd0, want.valid_res});
            end
         end
         if (start && !busy) expected_q.push_back(compensate(req_data));
         if (csr_we) begin
            case (csr_index)
               bpc_pkg::CSR_TEMP_TRIM:    trim_t  <= csr_wdata;
               bpc_pkg::CSR_PRESS_TRIM_A: trim_pa <= csr_wdata;
               bpc_pkg::CSR_PRESS_TRIM_B: trim_pb <= csr_wdata;
               bpc_pkg::CSR_PRESS_TRIM_C: trim_pc <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule

// File: tb/testbench.sv
// Top of the barometric pressure compensation testbench: clock, reset, stimulus, verdict.
// Instantiates barometric_pressure_compensation and bpc_checker; uses bpc_pkg.
`timescale 1ns / 100ps

module testbench;

   localparam int DRAIN_CYCLES = bpc_pkg::PIPE_DEPTH + 10;
   localparam int STALL_LIMIT  = 2000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   bpc_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   bpc_pkg::rsp_type               rsp_data;
   logic                           csr_we = 1'b0;
   logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bpc_pkg::TRIM_W-1:0]     csr_wdata = '0;
   int                             fail_count;
   int                             pending;
   int                             idle_cycles = 0;

   barometric_pressure_compensation u_dut (.*);
   bpc_checker u_checker (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [bpc_pkg::TRIM_W-1:0] rand_trim();
      return {16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
              16'($urandom_range(16'hFFFF, 0))};
   endfunction

   // plausible factory trims with random jitter
   function automatic logic [bpc_pkg::TRIM_W-1:0] typical_temp();
      return {16'd50 + 16'($urandom_range(20)) - 16'd10,
              16'd26435 + 16'($urandom_range(400)),
              16'd27504 + 16'($urandom_range(400))};
   endfunction

   function automatic logic [bpc_pkg::TRIM_W-1:0] typical_press(int k);
      case (k)
         1: return {16'hF3C7 + 16'($urandom_range(64)),
                    16'hD6D0 + 16'($urandom_range(64)),
                    16'd36477 + 16'($urandom_range(400))};
         2: return {16'hFFF9, 16'd140 + 16'($urandom_range(20)),
                    16'd2855 + 16'($urandom_range(100))};
         default: return {16'd6000 + 16'($urandom_range(200)), 16'hD8DC,
                          16'd15500 + 16'($urandom_range(100))};
      endcase
   endfunction

   task automatic write_trim(logic [bpc_pkg::CSR_IDX_W-1:0] idx,
                             logic [bpc_pkg::TRIM_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send(logic [19:0] rp, logic [19:0] rt, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(16) : 0;
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{raw_pressure: rp, raw_temperature: rt};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic end_burst();
      start <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [19:0] rp, rt;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero trims: divisor is zero
      send(20'h0, 20'h0, 0);
      send(20'hFFFFF, 20'hFFFFF, 0);
      end_burst();
      settle();
      write_trim(bpc_pkg::CSR_TEMP_TRIM, typical_temp());
      write_trim(bpc_pkg::CSR_PRESS_TRIM_A, typical_press(1));
      write_trim(bpc_pkg::CSR_PRESS_TRIM_B, typical_press(2));
      write_trim(bpc_pkg::CSR_PRESS_TRIM_C, typical_press(3));
      send(20'h0, 20'h0, 0);
      send(20'hFFFFF, 20'hFFFFF, 0);
      send(20'h0, 20'hFFFFF, 0);
      send(20'hFFFFF, 20'h0, 0);
      send(20'd415148, 20'd519888, 0);
      send(20'hAAAAA, 20'h55555, 1);
      send(20'h55555, 20'hAAAAA, 1);
      end_burst();
      settle();
      write_trim(bpc_pkg::CSR_TEMP_TRIM, '1);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_A, '1);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_B, '1);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_C, '1);
      send(20'h0, 20'h0, 0);
      send(20'hFFFFF, 20'hFFFFF, 0);
      send(20'h80000, 20'h80000, 0);
      end_burst();
      settle();
      write_trim(bpc_pkg::CSR_TEMP_TRIM, 48'h8000_8000_0000);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_A, 48'h8000_8000_FFFF);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_B, 48'h7FFF_7FFF_8000);
      write_trim(bpc_pkg::CSR_PRESS_TRIM_C, 48'h7FFF_8000_7FFF);
      send(20'h0, 20'hFFFFF, 0);
      send(20'hFFFFF, 20'h0, 0);
      end_burst();
      settle();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase % 3 == 2) begin
            write_trim(bpc_pkg::CSR_TEMP_TRIM, rand_trim());
            write_trim(bpc_pkg::CSR_PRESS_TRIM_A, rand_trim());
            write_trim(bpc_pkg::CSR_PRESS_TRIM_B, rand_trim());
            write_trim(bpc_pkg::CSR_PRESS_TRIM_C, rand_trim());
         end else begin
            write_trim(bpc_pkg::CSR_TEMP_TRIM, typical_temp());
            write_trim(bpc_pkg::CSR_PRESS_TRIM_A, typical_press(1));
            write_trim(bpc_pkg::CSR_PRESS_TRIM_B, typical_press(2));
            write_trim(bpc_pkg::CSR_PRESS_TRIM_C, typical_press(3));
         end
         // P1 cleared in phase 7: divisor collapses
         if (phase == 7)
            write_trim(bpc_pkg::CSR_PRESS_TRIM_A, rand_trim() & 48'hFFFF_FFFF_0000);
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(3) == 0) begin
               rp = 20'($urandom);
               rt = 20'($urandom);
            end else begin
               rp = 20'($urandom_range(600000, 200000));
               rt = 20'($urandom_range(600000, 400000));
            end
            send(rp, rt, phase % 4 != 1);
         end
         end_burst();
         settle();
      end

      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

// File: barometric_pressure_compensation.f
hdl/bpc_pkg.sv
hdl/bpc_front.sv
hdl/bpc_div.sv
hdl/bpc_back.sv
hdl/barometric_pressure_compensation.sv
tb/bpc_checker.sv
tb/testbench.sv
